### rtl/core/mvslt_pkg.sv
// Shared types, constants and helper functions for the MAC/VLAN socket lookup table.
// No dependencies; imported by every module of the block.
`default_nettype none

package mvslt_pkg;

	localparam int NUM_PORTS       = 4;
	localparam int NUM_BUCKETS     = 16;
	localparam int WAYS_PER_BUCKET = 4;

	localparam int TABLE_SIZE = NUM_PORTS * NUM_BUCKETS * WAYS_PER_BUCKET;
	localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int BKT_W      = $clog2(NUM_BUCKETS);
	localparam int WAY_W      = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
	localparam int CNT_W      = $clog2(WAYS_PER_BUCKET + 1);

	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int KEY_W      = 64;
	localparam int SOCK_W     = 8;
	localparam int HASH_LUT_N = 256;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_BIND   = 2'd1,
		OP_UNBIND = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_PORT  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PATH_DELIVER = 2'd0,
		PATH_SLOW    = 2'd1,
		PATH_DROP    = 2'd2
	} rx_path_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PORT_VALID  = 1'd0,
		REG_BRIDGE_PORT = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  port_index;
		logic [47:0] dst_mac;
		logic [15:0] vlan_id;
		logic [7:0]  socket_id;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] rx_path;
		logic [7:0] matched_socket;
	} out_word_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SOCK_W-1:0] sock;
	} entry_t;

	// requests from the sequencer to the entry store
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_entry;
		logic              vld_we;
		logic [ADDR_W-1:0] vld_addr;
		logic              vld_val;
	} mem_req_t;

	typedef struct packed {
		logic   vld;
		entry_t entry;
	} mem_rsp_t;

	typedef logic [BKT_W-1:0] bkt_lut_t [HASH_LUT_N];

	// folded hash byte -> bucket, built at elaboration
	function automatic bkt_lut_t mk_bkt_lut();
		bkt_lut_t lut;
		for (int i = 0; i < HASH_LUT_N; i++) begin
			lut[i] = BKT_W'(i % NUM_BUCKETS);
		end
		return lut;
	endfunction

	localparam bkt_lut_t BKT_LUT = mk_bkt_lut();

	function automatic logic [7:0] hash_byte(input logic [47:0] mac, input logic [15:0] vid);
		logic [7:0] x;
		x = vid[15:8] ^ vid[7:0];
		for (int i = 0; i < 6; i++) begin
			x = x ^ mac[8*i +: 8];
		end
		return x;
	endfunction

endpackage

`default_nettype wire

### rtl/core/mvslt_store.sv
// Entry store: key/socket memory with registered read, plus per-entry valid flops.
// Depends on mvslt_pkg.
`default_nettype none

module mvslt_store
	import mvslt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t req,
	output mem_rsp_t      rsp
);

	entry_t                mem [TABLE_SIZE];
	entry_t                rd_entry_q;
	logic                  rd_vld_q;
	logic [TABLE_SIZE-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_entry;
		end
		if (req.rd_en) begin
			rd_entry_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.vld_we) begin
				valid_q[req.vld_addr] <= req.vld_val;
			end
			if (req.rd_en) begin
				rd_vld_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rsp.vld   = rd_vld_q;
	assign rsp.entry = rd_entry_q;

endmodule

`default_nettype wire

### rtl/core/mvslt_ctrl.sv
// Sequencer: captures a word, scans the bucket ways one read per cycle through the
// shared key compare, then commits the table update and loads the result register.
// Depends on mvslt_pkg; drives mvslt_store through mem_req_t.
`default_nettype none

module mvslt_ctrl
	import mvslt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [MASK_W-1:0] port_valid_mask,
	input  wire logic [MASK_W-1:0] bridge_port_mask,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_word_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_word_t              out_data,
	output mem_req_t               mem_req,
	input  wire mem_rsp_t          mem_rsp
);

	state_t state_q, state_d;

	// captured word
	opcode_t            op_q;
	logic               in_range_q, port_ok_q, bridge_q;
	logic [KEY_W-1:0]   key_q;
	logic [SOCK_W-1:0]  sock_q;
	logic [ADDR_W-1:0]  base_q;

	// scan state
	logic [CNT_W-1:0]   cnt_q;
	logic               hit_q, free_q;
	logic [WAY_W-1:0]   hit_way_q, free_way_q;
	logic [SOCK_W-1:0]  hit_sock_q;

	logic               out_valid_q;
	out_word_t          out_data_q;

	logic               accept, need_scan, scan_done, cmp_en, key_eq, finish_go;
	logic               in_range, port_ok, bridge;
	logic [BKT_W-1:0]   bkt;
	logic [ADDR_W-1:0]  base;
	logic [WAY_W-1:0]   cmp_way;
	out_word_t          result;
	logic               do_bind_wr, do_unbind_clr;

	assign accept   = in_valid && in_ready;
	assign in_range = int'(in_data.port_index) < NUM_PORTS;
	assign port_ok  = in_range && port_valid_mask[in_data.port_index];
	assign bridge   = in_range && bridge_port_mask[in_data.port_index];
	assign bkt      = BKT_LUT[hash_byte(in_data.dst_mac, in_data.vlan_id)];
	assign base     = ADDR_W'((int'(in_data.port_index) * NUM_BUCKETS + int'(bkt))
		* WAYS_PER_BUCKET);

	always_comb begin
		case (opcode_t'(in_data.opcode))
			OP_LOOKUP, OP_BIND: need_scan = port_ok && !bridge;
			OP_UNBIND:          need_scan = in_range;
			default:            need_scan = 1'b0;
		endcase
	end

	assign scan_done = (cnt_q == CNT_W'(WAYS_PER_BUCKET));
	assign cmp_en    = (state_q == S_SCAN) && (cnt_q != '0);
	assign cmp_way   = WAY_W'(cnt_q - CNT_W'(1));
	assign key_eq    = mem_rsp.vld && (mem_rsp.entry.key == key_q);
	assign finish_go = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = need_scan ? S_SCAN : S_FINISH;
			S_SCAN:   if (scan_done) state_d = S_FINISH;
			S_FINISH: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// result and table update decided from the scan summary
	always_comb begin
		result        = '0;
		do_bind_wr    = 1'b0;
		do_unbind_clr = 1'b0;
		case (op_q)
			OP_LOOKUP: begin
				if (!port_ok_q) begin
					result.status  = ST_BAD_PORT;
					result.rx_path = PATH_DROP;
				end else if (bridge_q) begin
					result.status  = ST_BAD_PORT;
					result.rx_path = PATH_SLOW;
				end else if (hit_q) begin
					result.status         = ST_OK;
					result.rx_path        = PATH_DELIVER;
					result.matched_socket = hit_sock_q;
				end else begin
					result.status  = ST_NOT_FOUND;
					result.rx_path = PATH_SLOW;
				end
			end
			OP_BIND: begin
				if (!port_ok_q || bridge_q) begin
					result.status = ST_BAD_PORT;
				end else if (hit_q) begin
					result.status = ST_DUPLICATE;
				end else if (free_q) begin
					result.status = ST_OK;
					do_bind_wr    = 1'b1;
				end else begin
					result.status = ST_FULL;
				end
			end
			OP_UNBIND: begin
				if (!in_range_q) begin
					result.status = ST_BAD_PORT;
				end else if (hit_q) begin
					result.status = ST_OK;
					do_unbind_clr = 1'b1;
				end else begin
					result.status = ST_NOT_FOUND;
				end
			end
			default: result.status = ST_OK;
		endcase
	end

	// outputs
	always_comb begin
		in_ready          = (state_q == S_IDLE);
		mem_req           = '0;
		mem_req.rd_en     = (state_q == S_SCAN) && !scan_done;
		mem_req.rd_addr   = ADDR_W'(base_q + ADDR_W'(cnt_q[WAY_W-1:0]));
		mem_req.wr_en     = finish_go && do_bind_wr;
		mem_req.wr_addr   = ADDR_W'(base_q + ADDR_W'(free_way_q));
		mem_req.wr_entry  = '{key: key_q, sock: sock_q};
		mem_req.vld_we    = finish_go && (do_bind_wr || do_unbind_clr);
		mem_req.vld_addr  = do_bind_wr ? ADDR_W'(base_q + ADDR_W'(free_way_q))
			: ADDR_W'(base_q + ADDR_W'(hit_way_q));
		mem_req.vld_val   = do_bind_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (!scan_done) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				// first matching way and lowest free way
				if (cmp_en && key_eq && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cmp_en && !mem_rsp.vld && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode_t'(in_data.opcode);
			in_range_q <= in_range;
			port_ok_q  <= port_ok;
			bridge_q   <= bridge;
			key_q      <= {in_data.dst_mac, in_data.vlan_id};
			sock_q     <= in_data.socket_id;
			base_q     <= base;
		end
		if (cmp_en && key_eq && !hit_q) begin
			hit_way_q  <= cmp_way;
			hit_sock_q <= mem_rsp.entry.sock;
		end
		if (cmp_en && !mem_rsp.vld && !free_q) begin
			free_way_q <= cmp_way;
		end
		if (finish_go) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### rtl/core/mac_vlan_socket_lookup_table_top.sv
// MAC/VLAN socket lookup table, top level. One word at a time: a lookup, bind or unbind
// that reaches the table reads its bucket one way per cycle on the single read port, then
// makes the last compare and commits, loading the result into the output register.
// Words refused on port checks, and the unused opcode, skip the scan and go to the result.
// Next word is accepted in the cycle after the result is loaded into the output register.
// Reset clears all entry valid bits, both port masks and the control state at once.
`default_nettype none

module mac_vlan_socket_lookup_table_top
	import mvslt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_data
);

	logic [MASK_W-1:0] port_valid_mask_q, bridge_port_mask_q;
	mem_req_t          mem_req;
	mem_rsp_t          mem_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_valid_mask_q  <= '0;
			bridge_port_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PORT_VALID:  port_valid_mask_q  <= MASK_W'(cfg_wdata);
				REG_BRIDGE_PORT: bridge_port_mask_q <= MASK_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	mvslt_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.port_valid_mask  (port_valid_mask_q),
		.bridge_port_mask (bridge_port_mask_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data),
		.mem_req          (mem_req),
		.mem_rsp          (mem_rsp)
	);

	mvslt_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

`ifndef NO_ASSERTIONS
	// one word in flight: the sequencer must drop ready right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after accept");

	// a new result is only produced by a word that was being worked on
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while sequencer was idle");

	// the store is never read and written in the same cycle
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.vld_we))
		else $error("table read and update collided");

	// a socket is only reported on deliver
	a_socket_only_on_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.rx_path != PATH_DELIVER)) |-> (out_data.matched_socket == '0))
		else $error("matched_socket set without deliver");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for mac_vlan_socket_lookup_table_top: drives bind, unbind and
// lookup words with random idling on both sides and checks each result against a predictor.
// Depends on mvslt_pkg and the RTL of the block only.
`default_nettype none

module tb_top;
	import mvslt_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int SETTLE_TAIL  = 20;
	localparam int POOL_N       = 40;
	localparam int PHASE_WORDS  = 225;
	localparam int PHASES       = 6;

	typedef enum {
		STEP_WORD,
		STEP_SETTLE,
		STEP_CFG
	} step_kind_t;

	typedef struct {
		step_kind_t              kind;
		in_word_t                word;
		cfg_reg_t                cfg_sel;
		logic [CFG_DATA_W-1:0]   cfg_val;
	} tb_step_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_word_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;

	mac_vlan_socket_lookup_table_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [KEY_W-1:0]  tbl_key  [TABLE_SIZE];
	logic [SOCK_W-1:0] tbl_sock [TABLE_SIZE];
	bit                tbl_used [TABLE_SIZE];
	logic [MASK_W-1:0] valid_ports  = '0;
	logic [MASK_W-1:0] bridge_ports = '0;

	tb_step_t  pending_steps [$];
	out_word_t due_results   [$];
	out_word_t want_res;

	bit in_took  = 1'b0;
	bit out_took = 1'b0;
	int idle_cycles = 0;
	int errors      = 0;
	int n_words = 0, n_results = 0, n_deliver = 0, n_full = 0, n_cfg = 0;

	int send_gap = 0, recv_wait = 0;
	bit send_burst = 1'b0, recv_burst = 1'b0;
	bit tx_valid_nx, tx_we_nx;

	logic [47:0] pool_mac [POOL_N];
	logic [15:0] pool_vid [POOL_N];

	function automatic logic [7:0] fold_key(logic [47:0] mac, logic [15:0] vid);
		logic [63:0] k;
		logic [7:0]  x;
		k = {mac, vid};
		x = '0;
		for (int i = 0; i < 8; i++)
			x ^= k[8*i +: 8];
		return x;
	endfunction

	// applies one word to the predicted table and returns the result it should give
	function automatic out_word_t demux_step(in_word_t w);
		out_word_t   r;
		logic [63:0] key;
		bit          in_rng, pv, pb;
		int          base, hit, free_slot;
		r = '0;
		key = {w.dst_mac, w.vlan_id};
		in_rng = int'(w.port_index) < NUM_PORTS;
		pv = in_rng && valid_ports[w.port_index];
		pb = in_rng && bridge_ports[w.port_index];
		hit = -1;
		free_slot = -1;
		if (in_rng) begin
			base = (int'(w.port_index) * NUM_BUCKETS
				+ int'(fold_key(w.dst_mac, w.vlan_id)) % NUM_BUCKETS) * WAYS_PER_BUCKET;
			for (int s = base; s < base + WAYS_PER_BUCKET; s++) begin
				if (tbl_used[s] && tbl_key[s] == key && hit < 0)
					hit = s;
				if (!tbl_used[s] && free_slot < 0)
					free_slot = s;
			end
		end
		case (opcode_t'(w.opcode))
			OP_LOOKUP: begin
				if (!pv) begin
					r.status  = ST_BAD_PORT;
					r.rx_path = PATH_DROP;
				end else if (pb) begin
					r.status  = ST_BAD_PORT;
					r.rx_path = PATH_SLOW;
				end else if (hit < 0) begin
					r.status  = ST_NOT_FOUND;
					r.rx_path = PATH_SLOW;
				end else begin
					r.status         = ST_OK;
					r.rx_path        = PATH_DELIVER;
					r.matched_socket = tbl_sock[hit];
					n_deliver++;
				end
			end
			OP_BIND: begin
				if (!pv || pb) begin
					r.status = ST_BAD_PORT;
				end else if (hit >= 0) begin
					r.status = ST_DUPLICATE;
				end else if (free_slot < 0) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					r.status = ST_OK;
					tbl_used[free_slot] = 1'b1;
					tbl_key[free_slot]  = key;
					tbl_sock[free_slot] = w.socket_id;
				end
			end
			OP_UNBIND: begin
				if (!in_rng) begin
					r.status = ST_BAD_PORT;
				end else if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status = ST_OK;
					tbl_used[hit] = 1'b0;
				end
			end
			default: r.status = ST_OK;
		endcase
		return r;
	endfunction

	task automatic push_word(opcode_t op, logic [1:0] port, logic [47:0] mac,
			logic [15:0] vid, logic [7:0] sock);
		tb_step_t s;
		s.kind            = STEP_WORD;
		s.word.opcode     = op;
		s.word.port_index = port;
		s.word.dst_mac    = mac;
		s.word.vlan_id    = vid;
		s.word.socket_id  = sock;
		s.cfg_sel         = REG_PORT_VALID;
		s.cfg_val         = '0;
		pending_steps.push_back(s);
	endtask

	task automatic push_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
		tb_step_t s;
		s.kind    = STEP_CFG;
		s.word    = '0;
		s.cfg_sel = sel;
		s.cfg_val = val;
		pending_steps.push_back(s);
	endtask

	task automatic push_settle();
		tb_step_t s;
		s.kind    = STEP_SETTLE;
		s.word    = '0;
		s.cfg_sel = REG_PORT_VALID;
		s.cfg_val = '0;
		pending_steps.push_back(s);
	endtask

	// sender and receiver, both moving on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			tx_valid_nx = in_valid && !in_took;
			tx_we_nx = 1'b0;
			if (!tx_valid_nx) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_steps.size() != 0) begin
					case (pending_steps[0].kind)
						STEP_WORD: begin
							in_data <= pending_steps[0].word;
							tx_valid_nx = 1'b1;
							void'(pending_steps.pop_front());
							if ($urandom_range(0, 19) == 0)
								send_burst = !send_burst;
							send_gap = send_burst ? 0 : $urandom_range(0, 10);
						end
						STEP_SETTLE: begin
							if (due_results.size() == 0)
								void'(pending_steps.pop_front());
						end
						default: begin
							// registers only change with the table idle
							if (due_results.size() == 0) begin
								tx_we_nx = 1'b1;
								cfg_index <= pending_steps[0].cfg_sel;
								cfg_wdata <= pending_steps[0].cfg_val;
								void'(pending_steps.pop_front());
							end
						end
					endcase
				end
			end
			in_valid <= tx_valid_nx;
			cfg_we <= tx_we_nx;

			if (out_took) begin
				if ($urandom_range(0, 19) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0);
		end
	end

	// monitor: predicts on accepted words, checks accepted results
	always @(posedge clk) begin
		if (!arst_n) begin
			in_took <= 1'b0;
			out_took <= 1'b0;
			idle_cycles <= 0;
		end else begin
			in_took <= in_valid && in_ready;
			out_took <= out_valid && out_ready;
			if (cfg_we) begin
				n_cfg++;
				case (cfg_reg_t'(cfg_index))
					REG_PORT_VALID:  valid_ports = cfg_wdata;
					REG_BRIDGE_PORT: bridge_ports = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (due_results.size() == 0) begin
					$error("result %0d/%0d/%0d with no word pending",
						out_data.status, out_data.rx_path, out_data.matched_socket);
					errors++;
				end else begin
					want_res = due_results.pop_front();
					if (out_data.status !== want_res.status) begin
						$error("status: expected %0d, got %0d", want_res.status, out_data.status);
						errors++;
					end
					if (out_data.rx_path !== want_res.rx_path) begin
						$error("rx_path: expected %0d, got %0d", want_res.rx_path, out_data.rx_path);
						errors++;
					end
					if (out_data.matched_socket !== want_res.matched_socket) begin
						$error("matched_socket: expected %0d, got %0d",
							want_res.matched_socket, out_data.matched_socket);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				n_words++;
				due_results.push_back(demux_step(in_data));
			end
			idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				? 0 : idle_cycles + 1;
		end
	end

	initial begin
		logic [47:0] mac;
		logic [15:0] vid;
		logic [7:0]  h;
		int          r, k;
		opcode_t     op;
		logic [CFG_DATA_W-1:0] ph_valid [PHASES];
		logic [CFG_DATA_W-1:0] ph_bridge [PHASES];

		// masks still zero after reset: every port is invalid
		push_word(OP_LOOKUP, 2'd0, '1, '1, 8'h00);
		push_word(OP_BIND,   2'd2, 48'h0000_0000_0001, 16'h0001, 8'h11);
		push_word(OP_UNBIND, 2'd3, 48'h0000_0000_0001, 16'h0001, 8'h00);
		push_cfg(REG_PORT_VALID, 4'hF);
		push_cfg(REG_BRIDGE_PORT, 4'h0);
		push_word(OP_BIND,   2'd0, '1, '1, 8'hFF);
		push_word(OP_LOOKUP, 2'd0, '1, '1, 8'h00);
		push_word(OP_BIND,   2'd0, '1, '1, 8'h00);
		push_word(OP_LOOKUP, 2'd0, '0, '0, 8'hFF);
		// keys j: mac low byte j, vlan low byte j all fold to bucket zero
		for (int j = 1; j <= 5; j++)
			push_word(OP_BIND, 2'd1, 48'(j), 16'(j), 8'(j * 40));
		push_word(OP_LOOKUP, 2'd1, 48'd3, 16'd3, 8'h00);
		push_word(OP_UNBIND, 2'd1, 48'd2, 16'd2, 8'h00);
		push_word(OP_UNBIND, 2'd1, 48'd2, 16'd2, 8'h00);
		push_word(OP_BIND,   2'd1, 48'd5, 16'd5, 8'h00);
		push_word(OP_LOOKUP, 2'd1, 48'd5, 16'd5, 8'hFF);
		push_word(OP_NONE,   2'd0, 48'hA5A5_5A5A_A5A5, 16'h5A5A, 8'hAA);
		push_settle();
		push_cfg(REG_BRIDGE_PORT, 4'h2);
		push_cfg(REG_PORT_VALID, 4'h7);
		push_word(OP_LOOKUP, 2'd1, 48'd1, 16'd1, 8'h00);
		push_word(OP_BIND,   2'd1, 48'd6, 16'd6, 8'h12);
		push_word(OP_UNBIND, 2'd1, 48'd1, 16'd1, 8'h00);
		push_word(OP_LOOKUP, 2'd3, 48'd4, 16'd4, 8'h00);
		push_word(OP_LOOKUP, 2'd0, '1, '1, 8'h00);
		push_word(OP_UNBIND, 2'd0, '1, '1, 8'h00);
		push_word(OP_LOOKUP, 2'd0, '1, '1, 8'h00);

		// key pool packed into four buckets so ways fill up and free again
		for (int p = 0; p < POOL_N; p++) begin
			mac = 48'({$urandom, $urandom});
			vid = 16'($urandom);
			h = fold_key(mac, vid);
			vid[BKT_W-1:0] = vid[BKT_W-1:0] ^ h[BKT_W-1:0] ^ BKT_W'(p % 4);
			pool_mac[p] = mac;
			pool_vid[p] = vid;
		end

		ph_valid  = '{4'hF, 4'($urandom), 4'hF, 4'hF, 4'h0, 4'hF};
		ph_bridge = '{4'h0, 4'($urandom), 4'h0, 4'hF, 4'h0, 4'h5};
		for (int ph = 0; ph < PHASES; ph++) begin
			push_cfg(REG_PORT_VALID, ph_valid[ph]);
			push_cfg(REG_BRIDGE_PORT, ph_bridge[ph]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				r = $urandom_range(0, 99);
				op = (r < 40) ? OP_LOOKUP : (r < 70) ? OP_BIND : (r < 95) ? OP_UNBIND : OP_NONE;
				if ($urandom_range(0, 4) != 0) begin
					k = $urandom_range(0, POOL_N - 1);
					mac = pool_mac[k];
					vid = pool_vid[k];
				end else begin
					mac = 48'({$urandom, $urandom});
					vid = 16'($urandom);
				end
				push_word(op, 2'($urandom_range(0, 3)), mac, vid, 8'($urandom));
				if ($urandom_range(0, 149) == 0)
					push_settle();
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// checked on the rising edge, away from the sender's updates
		while (!(pending_steps.size() == 0 && !in_valid && due_results.size() == 0)
				&& idle_cycles < STALL_LIMIT)
			@(posedge clk);

		if (idle_cycles >= STALL_LIMIT) begin
			$display("mac_vlan_socket_lookup_table_top verification failed");
		end else begin
			repeat (SETTLE_TAIL) @(posedge clk);
			if (due_results.size() != 0) begin
				$error("%0d results never arrived", due_results.size());
				errors++;
			end
			$display("Ran %0d words through %0d register writes, %0d results checked",
				n_words, n_cfg, n_results);
			$display("Lookups delivered to a socket: %0d, binds refused on full bucket: %0d",
				n_deliver, n_full);
			if (errors == 0)
				$display("mac_vlan_socket_lookup_table_top verification clean");
			else
				$display("mac_vlan_socket_lookup_table_top verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
